[hw/rtl/qs_pkg.sv]
// Shared types, fixed-point formats and the arctangent table for the quaternion slerp block.
// Depends on nothing; every other file of the block refers to it by scoped names.
package qs_pkg;

  // Fixed-point formats.
  localparam int FRAC_BITS = 14;
  localparam int WORK_BITS = 30;
  localparam int SHIFT     = WORK_BITS - FRAC_BITS;
  localparam int ONE       = 1 << FRAC_BITS;

  // Field and datapath widths.
  localparam int COMP_W    = 16;
  localparam int COMPX_W   = COMP_W + 1;
  localparam int RATIO_W   = FRAC_BITS + 1;
  localparam int PROD4_W   = 2 * COMP_W;
  localparam int DOT_W     = PROD4_W + 2;
  localparam int CFULL_W   = DOT_W - 1 - FRAC_BITS;
  localparam int RAD_W     = 2 * FRAC_BITS + 1;
  localparam int SQRT_BITS = FRAC_BITS + 1;
  localparam int TRIAL_W   = 2 * SQRT_BITS + 1;
  localparam int CW        = WORK_BITS + 4;
  localparam int ATAN_W    = WORK_BITS;
  localparam int MAX_STEPS = 32;
  localparam int DIV_BITS  = WORK_BITS + FRAC_BITS + 2;
  localparam int MAG_W     = DIV_BITS - FRAC_BITS;
  localparam int K_W       = WORK_BITS + 4;
  localparam int PROD_W    = K_W + COMPX_W;

  localparam logic [CW-1:0]       INV_GAIN_Q30 = CW'(652032874);
  localparam logic [DIV_BITS-1:0] WEIGHT_LIMIT = DIV_BITS'(1) << (WORK_BITS + 2);
  localparam logic [RATIO_W-1:0]  THR_RESET    = RATIO_W'(2);

  typedef logic [COMP_W-1:0]          comp_t;
  typedef logic [3:0][COMP_W-1:0]     quat_t;
  typedef logic [3:0][COMPX_W-1:0]    quatx_t;
  typedef logic signed [CW-1:0]       cword_t;
  typedef logic signed [K_W-1:0]      weight_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  // Per-item sideband that travels with the pipeline.
  typedef struct packed {
    quat_t                 f;
    quatx_t                g;
    logic [RATIO_W-1:0]    t;
    logic                  lerp;
    logic [FRAC_BITS-1:0]  c;
    logic [SQRT_BITS-1:0]  s;
  } side_t;

  // atan(2^-i) in Q30 radians.
  function automatic logic [ATAN_W-1:0] atan_q30(input int i);
    logic [ATAN_W-1:0] v;
    case (i)
      0:  v = 30'd843314856;
      1:  v = 30'd497837829;
      2:  v = 30'd263043836;
      3:  v = 30'd133525158;
      4:  v = 30'd67021686;
      5:  v = 30'd33543515;
      6:  v = 30'd16775850;
      7:  v = 30'd8388437;
      8:  v = 30'd4194282;
      9:  v = 30'd2097149;
      10: v = 30'd1048575;
      11: v = 30'd524287;
      12: v = 30'd262143;
      13: v = 30'd131071;
      14: v = 30'd65535;
      15: v = 30'd32767;
      16: v = 30'd16383;
      17: v = 30'd8191;
      18: v = 30'd4095;
      19: v = 30'd2047;
      20: v = 30'd1023;
      21: v = 30'd511;
      22: v = 30'd255;
      23: v = 30'd127;
      24: v = 30'd63;
      25: v = 30'd31;
      26: v = 30'd15;
      27: v = 30'd8;
      28: v = 30'd4;
      29: v = 30'd2;
      30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/qs_if.sv]
// Valid/ready channel interfaces for the quaternion slerp block: input, result, configuration.
// Depends on qs_pkg for the field types.
interface qs_in_if;
  logic                       valid;
  logic                       ready;
  qs_pkg::comp_t              from_w;
  qs_pkg::comp_t              from_x;
  qs_pkg::comp_t              from_y;
  qs_pkg::comp_t              from_z;
  qs_pkg::comp_t              to_w;
  qs_pkg::comp_t              to_x;
  qs_pkg::comp_t              to_y;
  qs_pkg::comp_t              to_z;
  logic [qs_pkg::RATIO_W-1:0] ratio;

  modport source(output valid, from_w, from_x, from_y, from_z, to_w, to_x, to_y, to_z, ratio,
                 input ready);
  modport sink(input valid, from_w, from_x, from_y, from_z, to_w, to_x, to_y, to_z, ratio,
               output ready);
endinterface

interface qs_out_if;
  logic          valid;
  logic          ready;
  qs_pkg::comp_t out_w;
  qs_pkg::comp_t out_x;
  qs_pkg::comp_t out_y;
  qs_pkg::comp_t out_z;

  modport source(output valid, out_w, out_x, out_y, out_z, input ready);
  modport sink(input valid, out_w, out_x, out_y, out_z, output ready);
endinterface

interface qs_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [qs_pkg::RATIO_W-1:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

[hw/rtl/qs_cordic.sv]
// Pipelined CORDIC, one micro-rotation per register stage, in vectoring or rotation mode.
// Depends on qs_pkg for the word type and the arctangent table.
module qs_cordic #(
  parameter int STEPS  = 16,
  parameter bit VECTOR = 1'b0
) (
  input  logic           clk,
  input  logic           en,
  input  qs_pkg::cword_t x_i,
  input  qs_pkg::cword_t y_i,
  input  qs_pkg::cword_t z_i,
  output qs_pkg::cword_t res_o
);

  qs_pkg::cword_t x_r [STEPS];
  qs_pkg::cword_t y_r [STEPS];
  qs_pkg::cword_t z_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    qs_pkg::cword_t xin, yin, zin, x_nxt, y_nxt, z_nxt, dx, dy, at;
    logic           add_x;

    if (i == 0) begin : g_first
      assign xin = x_i;
      assign yin = y_i;
      assign zin = z_i;
    end else begin : g_next
      assign xin = x_r[i-1];
      assign yin = y_r[i-1];
      assign zin = z_r[i-1];
    end

    // Vectoring drives y toward zero, rotation drives z toward zero.
    always_comb begin
      dx    = yin >>> i;
      dy    = xin >>> i;
      at    = qs_pkg::cword_t'({{(qs_pkg::CW - qs_pkg::ATAN_W){1'b0}}, qs_pkg::atan_q30(i)});
      add_x = VECTOR ? !yin[qs_pkg::CW-1] : zin[qs_pkg::CW-1];
      x_nxt = add_x ? xin + dx : xin - dx;
      y_nxt = add_x ? yin - dy : yin + dy;
      z_nxt = add_x ? zin + at : zin - at;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
        z_r[i] <= z_nxt;
      end
    end
  end

  assign res_o = VECTOR ? z_r[STEPS-1] : y_r[STEPS-1];

endmodule

[hw/rtl/qs_div.sv]
// Pipelined restoring divider, one quotient bit per register stage, magnitude with sign.
// Depends on qs_pkg for the dividend and divisor widths.
module qs_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [qs_pkg::DIV_BITS-1:0]   num_i,
  input  logic [qs_pkg::SQRT_BITS-1:0]  den_i,
  input  logic                          neg_i,
  output logic [qs_pkg::DIV_BITS-1:0]   quo_o,
  output logic                          neg_o
);

  localparam int N = qs_pkg::DIV_BITS;
  localparam int D = qs_pkg::SQRT_BITS;

  logic [N-1:0] n_r   [N];
  logic [N-1:0] q_r   [N];
  logic [D-1:0] rem_r [N];
  logic [D-1:0] den_r [N];
  logic         neg_r [N];

  for (genvar j = 0; j < N; j++) begin : g_bit
    logic [N-1:0] nin, qin;
    logic [D-1:0] rin, din, r_nxt;
    logic         sin_neg, ge;
    logic [D:0]   rem2;

    if (j == 0) begin : g_first
      assign nin     = num_i;
      assign qin     = '0;
      assign rin     = '0;
      assign din     = den_i;
      assign sin_neg = neg_i;
    end else begin : g_next
      assign nin     = n_r[j-1];
      assign qin     = q_r[j-1];
      assign rin     = rem_r[j-1];
      assign din     = den_r[j-1];
      assign sin_neg = neg_r[j-1];
    end

    // Bring down the next dividend bit and subtract the divisor when it fits.
    always_comb begin
      rem2  = {rin, nin[N-1]};
      ge    = rem2 >= {1'b0, din};
      r_nxt = ge ? D'(rem2 - {1'b0, din}) : D'(rem2);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[j]   <= {nin[N-2:0], 1'b0};
        q_r[j]   <= {qin[N-2:0], ge};
        rem_r[j] <= r_nxt;
        den_r[j] <= din;
        neg_r[j] <= sin_neg;
      end
    end
  end

  assign quo_o = q_r[N-1];
  assign neg_o = neg_r[N-1];

endmodule

[hw/rtl/quaternion_slerp_top.sv]
// Quaternion slerp: a fully pipelined datapath that takes one word per cycle and gives one,
// except while a full output queue waits on the result side. It runs through the
// bit-serial square root, the vectoring and sine CORDIC chains and the 46-stage divider.
// Throughput is one word per cycle on the same condition; a two-entry output queue lets the
// pipeline advance while a result waits. rst_n (synchronous, active low) clears all valid
// bits and the queue and sets the threshold register to 2.
module quaternion_slerp_top #(
  parameter int CORDIC_STEPS = 16
) (
  input logic     clk,
  input logic     rst_n,
  qs_in_if.sink   in_ch,
  qs_out_if.source out_ch,
  qs_cfg_if.sink  cfg_ch
);

  localparam int STEPS = (CORDIC_STEPS > qs_pkg::MAX_STEPS) ? qs_pkg::MAX_STEPS : CORDIC_STEPS;
  localparam int P_D   = 1;
  localparam int P_SQ  = P_D + qs_pkg::SQRT_BITS;
  localparam int P_VEC = P_SQ + STEPS;
  localparam int P_M   = P_VEC + 1;
  localparam int P_SIN = P_M + STEPS;
  localparam int P_DIV = P_SIN + qs_pkg::DIV_BITS;
  localparam int P_W   = P_DIV + 1;
  localparam int P_P   = P_W + 1;
  localparam int FW    = qs_pkg::FRAC_BITS;
  localparam int RW    = qs_pkg::RATIO_W;
  localparam int CW    = qs_pkg::CW;

  // Threshold register.
  logic [RW-1:0] thr_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= qs_pkg::THR_RESET;
    end else if (cfg_ch.valid) begin
      thr_r <= cfg_ch.data;
    end
  end

  // Global advance: the pipeline moves whenever the output queue can take a word.
  logic [1:0] cnt_r;
  logic       en;

  assign en          = (cnt_r != 2'd2) || out_ch.ready;
  assign in_ch.ready = en;

  // Stage A: input register with the ratio clamped to one.
  logic          a_v_r;
  qs_pkg::quat_t a_f_r, a_g_r;
  logic [RW-1:0] a_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_f_r <= {in_ch.from_z, in_ch.from_y, in_ch.from_x, in_ch.from_w};
      a_g_r <= {in_ch.to_z, in_ch.to_y, in_ch.to_x, in_ch.to_w};
      a_t_r <= (in_ch.ratio > RW'(qs_pkg::ONE)) ? RW'(qs_pkg::ONE) : in_ch.ratio;
    end
  end

  // Stage B: the four component products.
  logic                              b_v_r;
  logic signed [qs_pkg::PROD4_W-1:0] b_prod_r [4];
  qs_pkg::quat_t                     b_f_r, b_g_r;
  logic [RW-1:0]                     b_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        b_prod_r[j] <= $signed(a_f_r[j]) * $signed(a_g_r[j]);
      end
      b_f_r <= a_f_r;
      b_g_r <= a_g_r;
      b_t_r <= a_t_r;
    end
  end

  // Dot product, short-arc flip and path choice.
  logic signed [qs_pkg::DOT_W-1:0] dot, absd;
  logic [qs_pkg::CFULL_W-1:0]      c_full;
  logic                            slerp;
  qs_pkg::quatx_t                  g_sel;

  always_comb begin
    dot = '0;
    for (int j = 0; j < 4; j++) begin
      dot = dot + qs_pkg::DOT_W'(b_prod_r[j]);
    end
    absd   = dot[qs_pkg::DOT_W-1] ? -dot : dot;
    c_full = absd[qs_pkg::DOT_W-2:FW];
    slerp  = ({1'b0, c_full} + (qs_pkg::CFULL_W + 1)'(thr_r))
             < (qs_pkg::CFULL_W + 1)'(qs_pkg::ONE);
    for (int j = 0; j < 4; j++) begin
      g_sel[j] = dot[qs_pkg::DOT_W-1] ? -qs_pkg::COMPX_W'($signed(b_g_r[j]))
                                     : qs_pkg::COMPX_W'($signed(b_g_r[j]));
    end
  end

  // Sideband line and valid bits from the dot stage to the product stage.
  qs_pkg::side_t             side_r [P_P+1];
  logic [P_P:0]              vld_r;
  logic [qs_pkg::RAD_W-1:0]  rem_r  [qs_pkg::SQRT_BITS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[P_P-1:0], b_v_r};
    end
  end

  for (genvar p = 0; p <= P_P; p++) begin : g_side
    if (p == 0) begin : g_dot
      always_ff @(posedge clk) begin
        if (en) begin
          side_r[p].f    <= b_f_r;
          side_r[p].g    <= g_sel;
          side_r[p].t    <= b_t_r;
          side_r[p].lerp <= !slerp;
          side_r[p].c    <= c_full[FW-1:0];
          side_r[p].s    <= '0;
        end
      end
    end else if (p == P_D) begin : g_rad
      // Radicand one squared minus c squared.
      always_ff @(posedge clk) begin
        if (en) begin
          side_r[p] <= side_r[p-1];
          rem_r[0]  <= (qs_pkg::RAD_W'(1) << (2 * FW))
                       - qs_pkg::RAD_W'(side_r[p-1].c) * qs_pkg::RAD_W'(side_r[p-1].c);
        end
      end
    end else if (p > P_D && p <= P_SQ) begin : g_sqrt
      // One root bit per stage, highest first.
      localparam int K = p - P_D - 1;
      localparam int B = qs_pkg::SQRT_BITS - 1 - K;
      logic [qs_pkg::TRIAL_W-1:0]  trial;
      logic                        ge;
      logic [qs_pkg::RAD_W-1:0]    r_nxt;
      qs_pkg::side_t               s_nxt;

      always_comb begin
        trial = (qs_pkg::TRIAL_W'(side_r[p-1].s) << (B + 1))
                + (qs_pkg::TRIAL_W'(1) << (2 * B));
        ge    = qs_pkg::TRIAL_W'(rem_r[K]) >= trial;
        r_nxt = ge ? qs_pkg::RAD_W'(qs_pkg::TRIAL_W'(rem_r[K]) - trial) : rem_r[K];
        s_nxt = side_r[p-1];
        if (ge) begin
          s_nxt.s = side_r[p-1].s | (qs_pkg::SQRT_BITS'(1) << B);
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          side_r[p]  <= s_nxt;
          rem_r[K+1] <= r_nxt;
        end
      end
    end else begin : g_copy
      always_ff @(posedge clk) begin
        if (en) begin
          side_r[p] <= side_r[p-1];
        end
      end
    end
  end

  // Angle between the quaternions by CORDIC vectoring on (c, s).
  qs_pkg::cword_t vec_x, vec_y, w_vec;

  assign vec_x = qs_pkg::cword_t'({{(CW - FW){1'b0}}, side_r[P_SQ].c}) <<< qs_pkg::SHIFT;
  assign vec_y = qs_pkg::cword_t'({{(CW - qs_pkg::SQRT_BITS){1'b0}}, side_r[P_SQ].s})
                 <<< qs_pkg::SHIFT;

  qs_cordic #(.STEPS(STEPS), .VECTOR(1'b1)) u_vec (
    .clk   (clk),
    .en    (en),
    .x_i   (vec_x),
    .y_i   (vec_y),
    .z_i   ('0),
    .res_o (w_vec)
  );

  // Stage M: partial angles t*w and (1-t)*w.
  qs_pkg::cword_t m_a0_r, m_a1_r;
  logic [RW-1:0]  t_m;
  logic [CW-1:0]  prod_a0, prod_a1;

  assign t_m = side_r[P_VEC].t;

  always_comb begin
    prod_a0 = CW'(({15'd0, w_vec[qs_pkg::WORK_BITS:0]} * (RW'(qs_pkg::ONE) - t_m)) >> FW);
    prod_a1 = CW'(({15'd0, w_vec[qs_pkg::WORK_BITS:0]} * t_m) >> FW);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_a0_r <= $signed(prod_a0);
      m_a1_r <= $signed(prod_a1);
    end
  end

  // Sines of both partial angles by CORDIC rotation.
  qs_pkg::cword_t sin0, sin1;

  qs_cordic #(.STEPS(STEPS), .VECTOR(1'b0)) u_sin0 (
    .clk   (clk),
    .en    (en),
    .x_i   ($signed(qs_pkg::INV_GAIN_Q30)),
    .y_i   ('0),
    .z_i   (m_a0_r),
    .res_o (sin0)
  );

  qs_cordic #(.STEPS(STEPS), .VECTOR(1'b0)) u_sin1 (
    .clk   (clk),
    .en    (en),
    .x_i   ($signed(qs_pkg::INV_GAIN_Q30)),
    .y_i   ('0),
    .z_i   (m_a1_r),
    .res_o (sin1)
  );

  // Divide each sine by sin w; the Q30 scaling reduces to a shift of FRAC_BITS.
  qs_pkg::cword_t                abs0, abs1;
  logic [qs_pkg::DIV_BITS-1:0]   num0, num1, quo0, quo1;
  logic                          neg0, neg1;

  assign abs0 = sin0[CW-1] ? -sin0 : sin0;
  assign abs1 = sin1[CW-1] ? -sin1 : sin1;
  assign num0 = {abs0[qs_pkg::MAG_W-1:0], {FW{1'b0}}};
  assign num1 = {abs1[qs_pkg::MAG_W-1:0], {FW{1'b0}}};

  qs_div u_div0 (
    .clk   (clk),
    .en    (en),
    .num_i (num0),
    .den_i (side_r[P_SIN].s),
    .neg_i (sin0[CW-1]),
    .quo_o (quo0),
    .neg_o (neg0)
  );

  qs_div u_div1 (
    .clk   (clk),
    .en    (en),
    .num_i (num1),
    .den_i (side_r[P_SIN].s),
    .neg_i (sin1[CW-1]),
    .quo_o (quo1),
    .neg_o (neg1)
  );

  // Stage W: saturated slerp weights or the plain linear weights.
  function automatic qs_pkg::weight_t sat_weight(input logic [qs_pkg::DIV_BITS-1:0] q,
                                                 input logic neg);
    logic [qs_pkg::DIV_BITS-1:0] mag;
    qs_pkg::weight_t             k;
    mag = (q > qs_pkg::WEIGHT_LIMIT) ? qs_pkg::WEIGHT_LIMIT : q;
    k   = qs_pkg::weight_t'(mag[qs_pkg::K_W-2:0]);
    return neg ? -k : k;
  endfunction

  qs_pkg::weight_t k0_r, k1_r;
  logic [RW-1:0]   t_w;

  assign t_w = side_r[P_DIV].t;

  always_ff @(posedge clk) begin
    if (en) begin
      if (side_r[P_DIV].lerp) begin
        k0_r <= qs_pkg::weight_t'({RW'(qs_pkg::ONE) - t_w, {qs_pkg::SHIFT{1'b0}}});
        k1_r <= qs_pkg::weight_t'({t_w, {qs_pkg::SHIFT{1'b0}}});
      end else begin
        k0_r <= sat_weight(quo0, neg0);
        k1_r <= sat_weight(quo1, neg1);
      end
    end
  end

  // Stage P: weighted component products.
  qs_pkg::prod_t pf_r [4];
  qs_pkg::prod_t pg_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        pf_r[j] <= qs_pkg::prod_t'(k0_r * $signed(side_r[P_W].f[j]));
        pg_r[j] <= qs_pkg::prod_t'(k1_r * $signed(side_r[P_W].g[j]));
      end
    end
  end

  // Round, shift down and saturate each component.
  logic signed [qs_pkg::PROD_W:0]                    acc [4];
  logic signed [qs_pkg::PROD_W-qs_pkg::WORK_BITS:0]  shr [4];
  qs_pkg::quat_t                                     res;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      acc[j] = (qs_pkg::PROD_W + 1)'(pf_r[j]) + (qs_pkg::PROD_W + 1)'(pg_r[j])
               + ((qs_pkg::PROD_W + 1)'(1) <<< (qs_pkg::WORK_BITS - 1));
      shr[j] = acc[j][qs_pkg::PROD_W:qs_pkg::WORK_BITS];
      if (shr[j] > $signed((qs_pkg::PROD_W - qs_pkg::WORK_BITS + 1)'(32767))) begin
        res[j] = 16'h7FFF;
      end else if (shr[j] < -$signed((qs_pkg::PROD_W - qs_pkg::WORK_BITS + 1)'(32768))) begin
        res[j] = 16'h8000;
      end else begin
        res[j] = shr[j][qs_pkg::COMP_W-1:0];
      end
    end
  end

  // Two-entry output queue.
  qs_pkg::quat_t head_r, tail_r;
  logic          push, pop;

  assign push = en && vld_r[P_P];
  assign pop  = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          head_r <= res;
        end else begin
          tail_r <= res;
        end
      end
      2'b01: begin
        head_r <= tail_r;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          head_r <= res;
        end else begin
          head_r <= tail_r;
          tail_r <= res;
        end
      end
      default: begin
        head_r <= head_r;
      end
    endcase
  end

  assign out_ch.valid = cnt_r != 2'd0;
  assign out_ch.out_w = head_r[0];
  assign out_ch.out_x = head_r[1];
  assign out_ch.out_y = head_r[2];
  assign out_ch.out_z = head_r[3];

`ifndef SYNTH
  // A stalled pipeline keeps every valid bit in place.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline valid bits moved during a stall");

  // A slerp word always leaves the square root with a nonzero sin w.
  a_sin_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[P_SQ] && !side_r[P_SQ].lerp) |-> (side_r[P_SQ].s != '0))
    else $error("slerp word with zero sine of the angle");

  // Linear weights always sum to one in Q30.
  a_lerp_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[P_W] && side_r[P_W].lerp)
      |-> ((k0_r + k1_r) == (qs_pkg::weight_t'(1) <<< qs_pkg::WORK_BITS)))
    else $error("linear weights do not sum to one");
`endif

endmodule

[dv/tb_top.sv]
// Testbench for quaternion_slerp_top: directed and random quaternion pairs checked word by
// word against a predictor of the fixed-point slerp. Depends on hw/rtl/qs_pkg.sv,
// hw/rtl/qs_if.sv and hw/rtl/quaternion_slerp_top.sv.
`timescale 1ns / 1ps

module tb_top;

  localparam int  STEPS      = 16;
  localparam int  LATENCY    = 68 + 2 * STEPS;
  localparam int  IDLE_LIMIT = 4000;
  localparam int  UNIT       = 1 << 14;

  typedef struct {
    logic signed [15:0] w, x, y, z;
  } quat_t;

  typedef struct {
    quat_t       from_q;
    quat_t       to_q;
    logic [14:0] ratio;
  } pair_t;

  // Arctangent of 2^-i in Q30 radians.
  localparam longint ATAN_TAB [32] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31, 15,
    8, 4, 2, 1, 0};

  logic clk;
  logic rst_n;

  qs_in_if  in_ch();
  qs_out_if out_ch();
  qs_cfg_if cfg_ch();

  quaternion_slerp_top #(.CORDIC_STEPS(STEPS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  logic [14:0] threshold_q;
  quat_t       expected_quats[$];
  int          error_count;
  int          words_sent;
  int          words_checked;
  int          cfg_writes;
  bit          stall_free;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Integer square root, bit by bit.
  function automatic longint int_sqrt(longint v);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // Vectoring CORDIC: angle of (x, y) in Q30.
  function automatic longint arc_angle(longint x, longint y);
    longint z;
    longint dx;
    longint dy;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end
    end
    return z;
  endfunction

  // Rotation CORDIC: sine of a Q30 angle.
  function automatic longint arc_sine(longint z);
    longint x;
    longint y;
    longint dx;
    longint dy;
    x = 652032874;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end
    end
    return y;
  endfunction

  function automatic longint blend_weight(longint sn, longint s30);
    longint q;
    q = (sn <<< 30) / s30;
    if (q > (64'sd1 <<< 32)) q = 64'sd1 <<< 32;
    if (q < -(64'sd1 <<< 32)) q = -(64'sd1 <<< 32);
    return q;
  endfunction

  // Expected interpolated quaternion for one pair under the current threshold.
  function automatic quat_t slerp_predict(pair_t p, logic [14:0] thr);
    longint f[4];
    longint g[4];
    longint d;
    longint t;
    longint c;
    longint s30;
    longint c30;
    longint ang;
    longint k0;
    longint k1;
    longint r[4];
    quat_t  q;
    f[0] = p.from_q.w; f[1] = p.from_q.x; f[2] = p.from_q.y; f[3] = p.from_q.z;
    g[0] = p.to_q.w;   g[1] = p.to_q.x;   g[2] = p.to_q.y;   g[3] = p.to_q.z;
    d = 0;
    for (int j = 0; j < 4; j++) d += f[j] * g[j];
    t = p.ratio;
    if (t > UNIT) t = UNIT;
    // Take the short arc.
    if (d < 0) begin
      d = -d;
      for (int j = 0; j < 4; j++) g[j] = -g[j];
    end
    c = d >>> 14;
    if (UNIT - c > longint'(thr)) begin
      s30 = int_sqrt(longint'(UNIT) * UNIT - c * c) <<< 16;
      c30 = c <<< 16;
      ang = arc_angle(c30, s30);
      k0 = blend_weight(arc_sine((ang * (UNIT - t)) >>> 14), s30);
      k1 = blend_weight(arc_sine((ang * t) >>> 14), s30);
    end else begin
      k0 = (UNIT - t) <<< 16;
      k1 = t <<< 16;
    end
    for (int j = 0; j < 4; j++) begin
      r[j] = (k0 * f[j] + k1 * g[j] + (64'sd1 <<< 29)) >>> 30;
      if (r[j] > 32767) r[j] = 32767;
      if (r[j] < -32768) r[j] = -32768;
    end
    q.w = r[0][15:0]; q.x = r[1][15:0]; q.y = r[2][15:0]; q.z = r[3][15:0];
    return q;
  endfunction

  // Send one word, with a random gap before it unless running stall free.
  task automatic send_pair(pair_t p);
    int gap;
    bit took;
    gap = stall_free ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.from_w <= p.from_q.w;
    in_ch.from_x <= p.from_q.x;
    in_ch.from_y <= p.from_q.y;
    in_ch.from_z <= p.from_q.z;
    in_ch.to_w   <= p.to_q.w;
    in_ch.to_x   <= p.to_q.x;
    in_ch.to_y   <= p.to_q.y;
    in_ch.to_z   <= p.to_q.z;
    in_ch.ratio  <= p.ratio;
    // Ready is settled between edges; the word is taken at the edge that follows.
    do begin
      @(negedge clk);
      took = in_ch.ready;
      @(posedge clk);
    end while (!took);
    expected_quats.push_back(slerp_predict(p, threshold_q));
    words_sent++;
  endtask

  // Wait for every expected word, then for the pipeline depth.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_quats.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_threshold(logic [14:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    threshold_q = value;
    cfg_writes++;
  endtask

  function automatic quat_t make_quat(int w, int x, int y, int z);
    quat_t q;
    q.w = w[15:0]; q.x = x[15:0]; q.y = y[15:0]; q.z = z[15:0];
    return q;
  endfunction

  function automatic quat_t raw_quat();
    return make_quat($urandom, $urandom, $urandom, $urandom);
  endfunction

  // Random quaternion of roughly unit length.
  function automatic quat_t unit_quat();
    real v[4];
    real n;
    v[0] = real'($urandom_range(0, 32768)) - 16384.0;
    v[1] = real'($urandom_range(0, 32768)) - 16384.0;
    v[2] = real'($urandom_range(0, 32768)) - 16384.0;
    v[3] = real'($urandom_range(0, 32768)) - 16384.0;
    n = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2] + v[3] * v[3]);
    if (n < 1.0) return make_quat(UNIT, 0, 0, 0);
    return make_quat($rtoi(v[0] * 16384.0 / n), $rtoi(v[1] * 16384.0 / n),
                     $rtoi(v[2] * 16384.0 / n), $rtoi(v[3] * 16384.0 / n));
  endfunction

  // Small perturbation of a quaternion, sometimes on the far hemisphere.
  function automatic quat_t near_quat(quat_t q);
    int spread;
    int sgn;
    int lim [4];
    spread = 1 << $urandom_range(0, 10);
    sgn = $urandom_range(0, 1) ? -1 : 1;
    lim[0] = sgn * q.w + $urandom_range(0, 2 * spread) - spread;
    lim[1] = sgn * q.x + $urandom_range(0, 2 * spread) - spread;
    lim[2] = sgn * q.y + $urandom_range(0, 2 * spread) - spread;
    lim[3] = sgn * q.z + $urandom_range(0, 2 * spread) - spread;
    for (int j = 0; j < 4; j++) begin
      if (lim[j] > 32767) lim[j] = 32767;
      if (lim[j] < -32768) lim[j] = -32768;
    end
    return make_quat(lim[0], lim[1], lim[2], lim[3]);
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int    kind;
    kind = $urandom_range(0, 9);
    p.from_q = (kind < 8) ? unit_quat() : raw_quat();
    if (kind < 5) p.to_q = unit_quat();
    else if (kind < 8) p.to_q = near_quat(p.from_q);
    else p.to_q = raw_quat();
    p.ratio = ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(0, UNIT));
    return p;
  endfunction

  function automatic pair_t make_pair(quat_t a, quat_t b, int r);
    pair_t p;
    p.from_q = a;
    p.to_q   = b;
    p.ratio  = r[14:0];
    return p;
  endfunction

  // Result side: random stalls, each word checked against the oldest expectation.
  initial begin
    int    gap;
    bit    took;
    quat_t got_q;
    quat_t exp_q;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = stall_free ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      // Valid and the word are settled between edges and taken at the next edge.
      do begin
        @(negedge clk);
        took    = out_ch.valid;
        got_q.w = out_ch.out_w;
        got_q.x = out_ch.out_x;
        got_q.y = out_ch.out_y;
        got_q.z = out_ch.out_z;
        @(posedge clk);
      end while (!took);
      if (expected_quats.size() == 0) begin
        $error("result word with nothing expected: %h %h %h %h",
               got_q.w, got_q.x, got_q.y, got_q.z);
        error_count++;
      end else begin
        exp_q = expected_quats.pop_front();
        words_checked++;
        if (got_q.w !== exp_q.w) begin
          $error("out_w expected %0d actual %0d", exp_q.w, got_q.w);
          error_count++;
        end
        if (got_q.x !== exp_q.x) begin
          $error("out_x expected %0d actual %0d", exp_q.x, got_q.x);
          error_count++;
        end
        if (got_q.y !== exp_q.y) begin
          $error("out_y expected %0d actual %0d", exp_q.y, got_q.y);
          error_count++;
        end
        if (got_q.z !== exp_q.z) begin
          $error("out_z expected %0d actual %0d", exp_q.z, got_q.z);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  int idle_cycles;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Corner pairs: extremes, identity, opposite arcs, non-unit inputs, ratio above one.
  task automatic test_directed();
    quat_t ident;
    quat_t a;
    quat_t b;
    ident = make_quat(UNIT, 0, 0, 0);
    a = make_quat(11585, 11585, 0, 0);
    b = make_quat(0, 0, 11585, -11585);
    send_pair(make_pair(ident, ident, 0));
    send_pair(make_pair(ident, ident, UNIT));
    send_pair(make_pair(ident, make_quat(0, UNIT, 0, 0), 8192));
    send_pair(make_pair(ident, make_quat(0, UNIT, 0, 0), 0));
    send_pair(make_pair(ident, make_quat(0, UNIT, 0, 0), UNIT));
    send_pair(make_pair(ident, make_quat(-UNIT, 0, 0, 0), 4096));
    send_pair(make_pair(a, make_quat(-11585, 0, -11585, 0), 8192));
    send_pair(make_pair(a, b, 5000));
    send_pair(make_pair(a, b, 32767));
    send_pair(make_pair(a, b, UNIT + 1));
    send_pair(make_pair(make_quat(32767, 32767, 32767, 32767),
                        make_quat(32767, 32767, 32767, 32767), 8192));
    send_pair(make_pair(make_quat(-32768, -32768, -32768, -32768),
                        make_quat(-32768, -32768, -32768, -32768), 16383));
    send_pair(make_pair(make_quat(-32768, -32768, -32768, -32768),
                        make_quat(32767, 32767, 32767, 32767), 1));
    send_pair(make_pair(make_quat(0, 0, 0, 0), make_quat(0, 0, 0, 0), 8192));
    send_pair(make_pair(make_quat(1, 0, 0, 0), make_quat(0, 1, 0, 0), 8192));
    send_pair(make_pair(make_quat(32767, 0, 0, 0), make_quat(0, -32768, 0, 0), 3000));
    send_pair(make_pair(ident, make_quat(16383, 181, 0, 0), 8192));
    send_pair(make_pair(ident, make_quat(16380, 0, 362, 0), 12000));
    send_pair(make_pair(make_quat(0, 0, 0, UNIT), make_quat(0, 0, UNIT, 1), 16384));
    send_pair(make_pair(make_quat(8192, 8192, 8192, 8192),
                        make_quat(8192, -8192, 8192, -8192), 10000));
    drain();
  endtask

  // One batch of random pairs under a given threshold.
  task automatic test_threshold(logic [14:0] thr, int count);
    write_threshold(thr);
    for (int i = 0; i < count; i++) send_pair(random_pair());
    drain();
  endtask

  // Back-to-back words with both sides never stalling.
  task automatic test_full_rate(int count);
    stall_free = 1'b1;
    for (int i = 0; i < count; i++) send_pair(random_pair());
    drain();
    stall_free = 1'b0;
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.from_w <= '0;
    in_ch.from_x <= '0;
    in_ch.from_y <= '0;
    in_ch.from_z <= '0;
    in_ch.to_w   <= '0;
    in_ch.to_x   <= '0;
    in_ch.to_y   <= '0;
    in_ch.to_z   <= '0;
    in_ch.ratio  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    threshold_q   = 15'd2;
    error_count   = 0;
    words_sent    = 0;
    words_checked = 0;
    cfg_writes    = 0;
    stall_free    = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_threshold(15'd0, 160);
    test_directed();
    test_threshold(15'd16384, 140);
    test_threshold(15'd32767, 100);
    test_threshold(15'($urandom), 150);
    test_threshold(15'($urandom_range(0, 600)), 200);
    test_threshold(15'd2, 200);
    test_full_rate(150);

    $display("sent %0d words, checked %0d results, %0d threshold writes",
             words_sent, words_checked, cfg_writes);
    $display("covered linear and spherical paths, short-arc flips, saturation and stalls");
    if (error_count == 0 && expected_quats.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", error_count, expected_quats.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/qs_pkg.sv
hw/rtl/qs_if.sv
hw/rtl/qs_cordic.sv
hw/rtl/qs_div.sv
hw/rtl/quaternion_slerp_top.sv
dv/tb_top.sv
